// ===== rtl/core/pilp_pkg.sv =====
// Package with the shared types, codes and constants of the integer literal parser.
package pilp_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_START  = 3'd5;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SYNTAX   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_MASK     = 2'd3;

  localparam logic [6:0]  MASK_WIDTH_RST = 7'd64;
  localparam logic [63:0] MAG_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_O  = 8'h6F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;

  // Classified character, as it travels from the front to the back
  typedef struct packed {
    logic       begin_req;
    logic       hexdig;     // 0-9, a-f or A-F
    logic [3:0] dval;       // digit value when hexdig
    logic       term;       // valid terminator
    logic       sign;       // '+' or '-'
    logic       minus;
    logic       pfx;        // lowercase x, o or b
    logic [1:0] pfx_radix;
  } token_t;

  typedef struct packed {
    logic   push;
    token_t tok;
  } q_wr_t;

  typedef struct packed {
    logic                 empty;
    logic                 full;
    logic [QueueCntW-1:0] count;
  } q_stat_t;

endpackage

// ===== rtl/core/pilp_front.sv =====
// Front end: accepts characters and classifies them into tokens for the queue.
module pilp_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  pilp_pkg::q_stat_t     q_stat,
  output pilp_pkg::q_wr_t       q_wr
);

  logic [7:0]       c;
  pilp_pkg::token_t tok;

  assign c = in_tdata;

  always_comb begin
    tok           = '0;
    tok.begin_req = in_tuser;
    if (c inside {[8'h30:8'h39]}) begin
      tok.hexdig = 1'b1;
      tok.dval   = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // low nibble of a-f / A-F is 1..6
      tok.hexdig = 1'b1;
      tok.dval   = c[3:0] + 4'd9;
    end
    tok.term = c inside {pilp_pkg::CH_NUL, pilp_pkg::CH_PLUS, pilp_pkg::CH_MINUS,
                         pilp_pkg::CH_STAR, pilp_pkg::CH_SLASH, pilp_pkg::CH_CARET,
                         pilp_pkg::CH_PIPE, pilp_pkg::CH_AMP, pilp_pkg::CH_PCT,
                         pilp_pkg::CH_EQ, pilp_pkg::CH_RPAREN, pilp_pkg::CH_COMMA};
    tok.sign  = (c == pilp_pkg::CH_PLUS) || (c == pilp_pkg::CH_MINUS);
    tok.minus = (c == pilp_pkg::CH_MINUS);
    case (c)
      pilp_pkg::CH_LOW_X: begin
        tok.pfx       = 1'b1;
        tok.pfx_radix = pilp_pkg::RADIX_HEX;
      end
      pilp_pkg::CH_LOW_O: begin
        tok.pfx       = 1'b1;
        tok.pfx_radix = pilp_pkg::RADIX_OCT;
      end
      pilp_pkg::CH_LOW_B: begin
        tok.pfx       = 1'b1;
        tok.pfx_radix = pilp_pkg::RADIX_BIN;
      end
      default: begin
        tok.pfx       = 1'b0;
        tok.pfx_radix = pilp_pkg::RADIX_DEC;
      end
    endcase
  end

  assign in_tready = !q_stat.full;
  assign q_wr.push = in_tvalid && !q_stat.full;
  assign q_wr.tok  = tok;

endmodule

// ===== rtl/core/pilp_queue.sv =====
// Short token queue between the front end and the parse engine.
module pilp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  pilp_pkg::q_wr_t    q_wr,
  input  logic               pop,
  output pilp_pkg::token_t   rd_tok,
  output pilp_pkg::q_stat_t  q_stat
);

  pilp_pkg::token_t                   mem [pilp_pkg::QueueDepth];
  logic [pilp_pkg::QueuePtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [pilp_pkg::QueueCntW-1:0]     count_r, count_nxt;
  logic                               do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == pilp_pkg::QueueCntW'(pilp_pkg::QueueDepth));
  assign q_stat.count = count_r;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_tok       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (q_wr.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_wr.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr_r] <= q_wr.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/pilp_back.sv =====
// Parse engine: literal state machine, accumulator, range checks and result register.
module pilp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  pilp_pkg::token_t  tok,
  output logic              tok_take,
  input  logic [6:0]        mask_width,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [63:0]       res_value,
  output logic [1:0]        res_status
);

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  radix_r, radix_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic        seen_r, seen_nxt;

  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [1:0]  out_status_r;

  logic [2:0]  e_phase;
  logic [1:0]  e_radix;
  logic        e_neg, e_ovf, e_seen;
  logic [63:0] e_acc;

  logic        dig_dec, dig_rad, dig_use;
  logic [1:0]  step_radix;
  logic [67:0] acc_w, prod;
  logic        prod_ovf;
  logic        fin;
  logic [63:0] fin_value, signed_val, hi_mask;
  logic [1:0]  fin_status;
  logic [5:0]  wm1;
  logic        fits;

  assign tok_take = tok_valid && (!out_valid_r || res_ready);

  // A begin flag restarts the literal from clean state
  always_comb begin
    e_phase = tok.begin_req ? pilp_pkg::PH_START  : phase_r;
    e_radix = tok.begin_req ? pilp_pkg::RADIX_DEC : radix_r;
    e_neg   = tok.begin_req ? 1'b0  : neg_r;
    e_acc   = tok.begin_req ? 64'd0 : acc_r;
    e_ovf   = tok.begin_req ? 1'b0  : ovf_r;
    e_seen  = tok.begin_req ? 1'b0  : seen_r;
  end

  always_comb begin
    dig_dec = tok.hexdig && (tok.dval < 4'd10);
    case (e_radix)
      pilp_pkg::RADIX_HEX: dig_rad = tok.hexdig;
      pilp_pkg::RADIX_OCT: dig_rad = tok.hexdig && !tok.dval[3];
      pilp_pkg::RADIX_BIN: dig_rad = tok.hexdig && (tok.dval[3:1] == 3'd0);
      default:             dig_rad = dig_dec;
    endcase
  end

  // Shift-add step; the product stays exact in 68 bits
  always_comb begin
    step_radix = e_radix;
    acc_w      = {4'd0, e_acc};
    case (step_radix)
      pilp_pkg::RADIX_HEX: prod = (acc_w << 4) + {64'd0, tok.dval};
      pilp_pkg::RADIX_OCT: prod = (acc_w << 3) + {64'd0, tok.dval};
      pilp_pkg::RADIX_BIN: prod = (acc_w << 1) + {64'd0, tok.dval};
      default:             prod = (acc_w << 3) + (acc_w << 1) + {64'd0, tok.dval};
    endcase
    prod_ovf = prod > {4'd0, pilp_pkg::MAG_MAX};
  end

  // Sign extension check against the configured width, and the final status and value
  always_comb begin
    signed_val = e_neg ? (64'd0 - e_acc) : e_acc;
    wm1        = (mask_width == 7'd0) ? 6'd0 : 6'(mask_width - 7'd1);
    hi_mask    = ~((64'd1 << wm1) - 64'd1);
    fits       = (mask_width >= 7'd64) ||
                 ((signed_val & hi_mask) == hi_mask) ||
                 ((signed_val & hi_mask) == 64'd0);
    fin_value  = 64'd0;
    if (!tok.term || !e_seen) begin
      fin_status = pilp_pkg::ST_SYNTAX;
    end else if (e_ovf) begin
      fin_status = pilp_pkg::ST_OVERFLOW;
    end else if (fits) begin
      fin_status = pilp_pkg::ST_OK;
      fin_value  = signed_val;
    end else begin
      fin_status = pilp_pkg::ST_MASK;
    end
  end

  always_comb begin
    phase_nxt = e_phase;
    radix_nxt = e_radix;
    neg_nxt   = e_neg;
    acc_nxt   = e_acc;
    ovf_nxt   = e_ovf;
    seen_nxt  = e_seen;
    fin       = 1'b0;
    dig_use   = 1'b0;
    case (e_phase)
      pilp_pkg::PH_START, pilp_pkg::PH_SIGN: begin
        if (e_phase == pilp_pkg::PH_START && tok.sign) begin
          neg_nxt   = tok.minus;
          phase_nxt = pilp_pkg::PH_SIGN;
        end else if (tok.hexdig && tok.dval == 4'd0) begin
          seen_nxt  = 1'b1;
          phase_nxt = pilp_pkg::PH_ZERO;
        end else if (dig_dec) begin
          dig_use = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      pilp_pkg::PH_ZERO: begin
        if (tok.pfx) begin
          radix_nxt = tok.pfx_radix;
          seen_nxt  = 1'b0;
          phase_nxt = pilp_pkg::PH_PREFIX;
        end else if (dig_dec) begin
          dig_use = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      pilp_pkg::PH_PREFIX, pilp_pkg::PH_DIGITS: begin
        if (dig_rad) begin
          dig_use = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        phase_nxt = e_phase;
      end
    endcase
    if (dig_use) begin
      seen_nxt  = 1'b1;
      phase_nxt = pilp_pkg::PH_DIGITS;
      if (!e_ovf) begin
        if (prod_ovf) begin
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = prod[63:0];
        end
      end
    end
    if (fin) begin
      phase_nxt = pilp_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pilp_pkg::PH_IDLE;
      radix_r     <= pilp_pkg::RADIX_DEC;
      neg_r       <= 1'b0;
      acc_r       <= 64'd0;
      ovf_r       <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tok_take) begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        seen_r  <= seen_nxt;
      end
      if (tok_take && fin) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && fin) begin
      out_value_r  <= fin_value;
      out_status_r <= fin_status;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_value  = out_value_r;
  assign res_status = out_status_r;

endmodule

// ===== rtl/core/prefixed_int_literal_parser_top.sv =====
// Top level of the prefixed integer literal parser.
// Takes one character per clock and returns one result per literal closed before
// the next begin flag: the signed value and a status (0 ok, 1 syntax, 2 int64
// overflow, 3 exceeds mask_width). A character is taken every cycle while the
// 4-entry token queue has room; the parse engine consumes one token per cycle,
// its shift-add and 68-bit overflow compare setting that rate. A terminating
// character goes into the token queue; its result is registered in the output
// register when the engine takes that token and waits there while later
// characters keep flowing; the engine stalls only on a held, untaken result.
module prefixed_int_literal_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] begin_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] value, [65:64] status, [71:66] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // mask_width
);

  logic [6:0]         mask_width_r;
  pilp_pkg::q_wr_t    q_wr;
  pilp_pkg::q_stat_t  q_stat;
  pilp_pkg::token_t   rd_tok;
  logic               tok_take;
  logic [63:0]        res_value;
  logic [1:0]         res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_width_r <= pilp_pkg::MASK_WIDTH_RST;
    end else if (cfg_valid) begin
      mask_width_r <= cfg_data;
    end
  end

  pilp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_wr      (q_wr)
  );

  pilp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (tok_take),
    .rd_tok (rd_tok),
    .q_stat (q_stat)
  );

  pilp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (!q_stat.empty),
    .tok        (rd_tok),
    .tok_take   (tok_take),
    .mask_width (mask_width_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_value  (res_value),
    .res_status (res_status)
  );

  assign out_tdata = {6'd0, res_status, res_value};

  // Backpressure on the input only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full)
    else $error("input stalled with room in the queue");

  // Queue occupancy tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> q_stat.count ==
      $past(q_stat.count) + (pilp_pkg::QueueCntW)'($past(q_wr.push))
                          - (pilp_pkg::QueueCntW)'($past(tok_take)))
    else $error("queue count out of step");

  // A failed literal carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_status != pilp_pkg::ST_OK) |-> res_value == 64'd0)
    else $error("nonzero value with error status");

endmodule

// ===== sim/pilp_result_checker.sv =====
// Checker that mirrors the literal parser, predicts each result and compares it at the output.
`timescale 1ns / 1ps

module pilp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] begin_req
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // [63:0] value, [65:64] status, [71:66] zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,   // mask_width
  output int          fail_count,
  output int          pending
);
  import pilp_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } lit_result_t;

  lit_result_t lit_expected[$];

  logic [2:0]  lit_phase;
  logic [1:0]  lit_radix;
  logic        lit_neg;
  logic [63:0] lit_mag;
  logic        lit_ovf;
  logic        lit_digit;
  logic [6:0]  mask_bits;

  int err_total = 0;
  int held = 0;

  assign fail_count = err_total;
  assign pending    = held;

  function automatic void clear_literal();
    lit_phase = PH_IDLE;
    lit_radix = RADIX_DEC;
    lit_neg   = 1'b0;
    lit_mag   = '0;
    lit_ovf   = 1'b0;
    lit_digit = 1'b0;
  endfunction

  function automatic int digit_of(logic [7:0] c, logic [1:0] rdx);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    case (rdx)
      RADIX_HEX: return d;
      RADIX_OCT: return (d < 8) ? d : -1;
      RADIX_BIN: return (d < 2) ? d : -1;
      default:   return (d < 10) ? d : -1;
    endcase
  endfunction

  function automatic logic [63:0] base_of(logic [1:0] rdx);
    case (rdx)
      RADIX_HEX: return 64'd16;
      RADIX_OCT: return 64'd8;
      RADIX_BIN: return 64'd2;
      default:   return 64'd10;
    endcase
  endfunction

  function automatic void add_digit(int d);
    logic [63:0] b;
    logic [63:0] du;
    b  = base_of(lit_radix);
    du = 64'(d);
    lit_digit = 1'b1;
    lit_phase = PH_DIGITS;
    // once the magnitude has overflowed, only keep consuming digits
    if (!lit_ovf) begin
      if (lit_mag > (MAG_MAX - du) / b) lit_ovf = 1'b1;
      else lit_mag = lit_mag * b + du;
    end
  endfunction

  function automatic logic is_term(logic [7:0] c);
    case (c)
      CH_NUL, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET,
      CH_PIPE, CH_AMP, CH_PCT, CH_EQ, CH_RPAREN, CH_COMMA: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic fits_mask(logic [63:0] v);
    int          w;
    logic [63:0] m;
    logic [63:0] x;
    w = mask_bits;
    if (w == 0) w = 1;
    if (w >= 64) return 1'b1;
    m = (64'd1 << w) - 64'd1;
    x = v & m;
    if (x[w-1]) x = x | ~m;
    return x == v;
  endfunction

  function automatic void close_literal(logic [7:0] c);
    lit_result_t r;
    r.value = '0;
    if (!is_term(c) || !lit_digit) begin
      r.status = ST_SYNTAX;
    end else if (lit_ovf) begin
      r.status = ST_OVERFLOW;
    end else begin
      r.value = lit_neg ? (64'd0 - lit_mag) : lit_mag;
      if (fits_mask(r.value)) begin
        r.status = ST_OK;
      end else begin
        r.status = ST_MASK;
        r.value  = '0;
      end
    end
    lit_phase = PH_IDLE;
    lit_expected.push_back(r);
  endfunction

  function automatic void absorb_char(logic [7:0] c, logic beg);
    int d;
    if (beg) begin
      clear_literal();
      lit_phase = PH_START;
    end
    case (lit_phase)
      PH_START, PH_SIGN: begin
        if (lit_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
          lit_neg   = (c == CH_MINUS);
          lit_phase = PH_SIGN;
        end else if (c == "0") begin
          lit_digit = 1'b1;
          lit_phase = PH_ZERO;
        end else begin
          d = digit_of(c, RADIX_DEC);
          if (d >= 0) add_digit(d);
          else close_literal(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_LOW_X || c == CH_LOW_O || c == CH_LOW_B) begin
          lit_radix = (c == CH_LOW_X) ? RADIX_HEX : (c == CH_LOW_O) ? RADIX_OCT : RADIX_BIN;
          lit_digit = 1'b0;
          lit_phase = PH_PREFIX;
        end else begin
          d = digit_of(c, RADIX_DEC);
          if (d >= 0) add_digit(d);
          else close_literal(c);
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        d = digit_of(c, lit_radix);
        if (d >= 0) add_digit(d);
        else close_literal(c);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    lit_result_t want;
    if (!rst_n) begin
      clear_literal();
      mask_bits = MASK_WIDTH_RST;
      lit_expected.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (lit_expected.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got %h", $time, out_tdata);
          err_total++;
        end else begin
          want = lit_expected.pop_front();
          if (out_tdata[63:0] !== want.value) begin
            $display("%0t: value mismatch: expected %h, got %h",
                     $time, want.value, out_tdata[63:0]);
            err_total++;
          end
          if (out_tdata[65:64] !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_tdata[65:64]);
            err_total++;
          end
          if (out_tdata[71:66] !== 6'd0) begin
            $display("%0t: padding mismatch: expected %h, got %h",
                     $time, 6'd0, out_tdata[71:66]);
            err_total++;
          end
        end
      end
      if (cfg_valid && cfg_ready) mask_bits = cfg_data;
      if (in_tvalid && in_tready) absorb_char(in_tdata, in_tuser);
    end
    held = lit_expected.size();
  end

endmodule

// ===== sim/prefixed_int_literal_parser_top_test.sv =====
// Testbench top for the literal parser: clock, reset, character stimulus and the verdict.
`timescale 1ns / 1ps

module prefixed_int_literal_parser_top_test;
  import pilp_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int LongHoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  int fail_count;
  int pending;

  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;

  // {begin_req, ch} per character, in send order
  logic [8:0] char_plan[$];
  int         plan_count;

  always #1 clk = ~clk;

  prefixed_int_literal_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pilp_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic add_char(logic beg, logic [7:0] c);
    char_plan.push_back({beg, c});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(i == 0, s[i]);
  endtask

  function automatic logic [7:0] term_char(int i);
    case (i)
      0:       return CH_NUL;
      1:       return CH_PLUS;
      2:       return CH_MINUS;
      3:       return CH_STAR;
      4:       return CH_SLASH;
      5:       return CH_CARET;
      6:       return CH_PIPE;
      7:       return CH_AMP;
      8:       return CH_PCT;
      9:       return CH_EQ;
      10:      return CH_RPAREN;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(logic [4:0] dv);
    if (dv < 10) return "0" + dv;
    return 8'(($urandom_range(0, 1) ? "a" : "A") + dv - 10);
  endfunction

  function automatic logic [6:0] mask_for(int ph);
    case (ph)
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd127;
      3:       return 7'd63;
      4:       return 7'd8;
      5:       return 7'($urandom_range(1, 64));
      6:       return 7'($urandom_range(0, 127));
      default: return MASK_WIDTH_RST;
    endcase
  endfunction

  // Append one random literal: mostly well formed, sometimes broken or plain noise.
  task automatic plan_literal();
    logic [7:0]  text[$];
    logic [7:0]  digs[$];
    logic [63:0] mag;
    logic [63:0] base;
    logic [1:0]  rdx;
    logic [7:0]  pfx;
    int          n;
    int          extra;
    int          r;
    if ($urandom_range(0, 14) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) add_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      return;
    end
    rdx = 2'($urandom_range(0, 3));
    case (rdx)
      RADIX_HEX: begin base = 64'd16; pfx = CH_LOW_X; end
      RADIX_OCT: begin base = 64'd8;  pfx = CH_LOW_O; end
      RADIX_BIN: begin base = 64'd2;  pfx = CH_LOW_B; end
      default:   begin base = 64'd10; pfx = CH_LOW_X; end
    endcase
    r = $urandom_range(0, 3);
    if (r == 0) text.push_back(CH_PLUS);
    else if (r == 1) text.push_back(CH_MINUS);
    if (rdx != RADIX_DEC) begin
      text.push_back("0");
      // shift to uppercase now and then: not a prefix any more
      if ($urandom_range(0, 11) == 0) pfx = pfx - 8'h20;
      text.push_back(pfx);
    end
    extra = 0;
    if ($urandom_range(0, 19) != 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mag = 64'($urandom_range(0, 300));
        4, 5: begin
          n = $urandom_range(1, 64);
          mag = {$urandom, $urandom} >> (64 - n);
        end
        6: begin
          n = $urandom_range(0, 63);
          mag = (64'd1 << n) + 64'($urandom_range(0, 2)) - 64'd1;
        end
        7: mag = MAG_MAX + 64'($urandom_range(0, 2)) - 64'd1;
        8: begin
          mag = {$urandom, $urandom};
          extra = $urandom_range(1, 3);
        end
        default: mag = '0;
      endcase
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) text.push_back("0");
      if (mag == 0) digs.push_back("0");
      while (mag != 0) begin
        digs.push_front(digit_char(5'(mag % base)));
        mag = mag / base;
      end
      repeat (extra) digs.push_back(digit_char(5'($urandom_range(0, 32'(base) - 1))));
      foreach (digs[i]) text.push_back(digs[i]);
    end
    r = $urandom_range(0, 19);
    if (r < 15) text.push_back(term_char($urandom_range(0, 11)));
    else if (r < 18) text.push_back(8'($urandom_range(0, 255)));
    foreach (text[i]) add_char(i == 0, text[i]);
    plan_count += text.size();
    if ($urandom_range(0, 7) == 0) add_char(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // Drain the plan in bursts with random gaps; hold each transaction until accepted.
  task automatic play_plan();
    logic [8:0] it;
    int         burst;
    int         gap;
    burst = 0;
    while (char_plan.size() > 0) begin
      if (burst == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          burst = 300;
          gap   = 0;
        end else begin
          burst = $urandom_range(1, 24);
          gap   = $urandom_range(0, 5);
        end
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          in_tdata  <= 8'($urandom);
          in_tuser  <= 1'($urandom);
          repeat (gap) @(posedge clk);
        end
      end
      it = char_plan.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= it[7:0];
      in_tuser  <= it[8];
      do @(posedge clk); while (!in_tready);
      burst--;
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mask(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: changing ready pattern, plus one long hold-off on request.
  initial begin
    int mode;
    int tick;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold_done = 1'b1;
      end
      if (tick == 0) begin
        mode = $urandom_range(0, 3);
        tick = $urandom_range(16, 96);
      end
      tick--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog: end the run after too long without any transaction.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WatchdogLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset mask width
    add_char(1'b0, "q");          // idle without begin: dropped
    add_text("-0x1F)");           // sign before prefix, uppercase hex digits
    add_text("-");                // lone sign
    add_char(1'b0, CH_NUL);
    add_text("0b+");              // bare prefix
    add_text("0");                // lone zero
    add_char(1'b0, CH_NUL);
    add_text("0X");               // uppercase prefix letter
    add_text("12");               // dropped by the next begin
    add_text("5=");
    add_text("1");
    add_char(1'b0, 8'hFF);
    add_text("0o7g");
    play_plan();
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      write_mask(mask_for(ph));
      plan_count = 0;
      while (plan_count < 175) plan_literal();
      add_char(1'b0, CH_COMMA);   // close a literal left open
      if (ph == 2) long_hold_req = 1'b1;
      play_plan();
      settle();
    end

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== prefixed_int_literal_parser_top.f =====
rtl/core/pilp_pkg.sv
rtl/core/pilp_front.sv
rtl/core/pilp_queue.sv
rtl/core/pilp_back.sv
rtl/core/prefixed_int_literal_parser_top.sv
sim/pilp_result_checker.sv
sim/prefixed_int_literal_parser_top_test.sv
